// ===== rtl/core/epc_pkg.sv =====
package epc_pkg;

    // coordinate format
    localparam int CW = 32;              // signed coordinate width
    localparam int RW = CW - 1;          // unsigned radius width
    localparam int DW = CW + 1;          // exact width of |target - centre|
    localparam int EW = CW + 2;          // headroom width for the final sums
    localparam int PW = 64;              // width of the exact products A, B, P
    localparam int HW = PW / 2;          // half of a product, one partial-product operand
    localparam int QW = 2 * PW;          // width of a squared product
    localparam int LW = 7;               // bit length of a product, 0..64
    localparam int NW = 31;              // normalized magnitude width
    localparam int SW = 2 * (NW + 1);    // radicand width of the square root
    localparam int RTW = SW / 2;         // root width
    localparam int RMW = RTW + 2;        // square-root remainder width
    localparam int UW = 32;              // unit-vector component width, U1.31
    localparam int UNIT_SHIFT = 31;
    localparam int SQ_STEPS = RTW;       // one root bit per stage
    localparam int DIV_STEPS = UW;       // one quotient bit per stage

    typedef enum logic [1:0] {
        KIND_GEN,
        KIND_RX0,
        KIND_RY0
    } epc_kind_t;

    typedef struct packed {
        logic                 mode;
        logic signed [CW-1:0] center_x;
        logic signed [CW-1:0] center_y;
        logic [RW-1:0]        radius_x;
        logic [RW-1:0]        radius_y;
        logic signed [CW-1:0] target_x;
        logic signed [CW-1:0] target_y;
    } epc_in_t;

    typedef struct packed {
        logic signed [CW-1:0] out_x;
        logic signed [CW-1:0] out_y;
        logic                 moved;
        logic                 degenerate;
    } epc_out_t;

    // per-item context that rides along the pipeline
    typedef struct packed {
        epc_kind_t            kind;
        logic                 mode;
        logic                 zero;
        logic                 in_ell;
        logic                 neg_x;
        logic                 neg_y;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [CW-1:0] tx;
        logic signed [CW-1:0] ty;
        logic [RW-1:0]        rx;
        logic [RW-1:0]        ry;
    } epc_ctx_t;

    typedef struct packed {
        logic [PW-1:0] hh;
        logic [PW-1:0] hl;
        logic [PW-1:0] ll;
    } epc_parts_t;

endpackage

// ===== rtl/core/ellipse_point_clamp.sv =====
// the pipeline has 6 front stages, 32 square-root stages, 32 divider stages, 1 scaling
//   stage and 1 output register
// throughput: one item per cycle; the whole pipeline advances whenever the output
//   register is empty or being taken, so a stall on m_ready holds every stage
// reset: aresetn is synchronous, active low, and clears every valid bit; data
//   registers are not reset
module ellipse_point_clamp (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  epc_pkg::epc_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output epc_pkg::epc_out_t m_data
);

    // saturate a headroom value to the signed coordinate range
    function automatic logic signed [epc_pkg::CW-1:0] sat_c(
        input logic signed [epc_pkg::EW-1:0] v
    );
        logic signed [epc_pkg::EW-1:0] hi;
        logic signed [epc_pkg::EW-1:0] lo;
        hi = $signed({{(epc_pkg::EW-epc_pkg::CW+1){1'b0}}, {(epc_pkg::CW-1){1'b1}}});
        lo = -hi - epc_pkg::EW'(1);
        if (v > hi) begin
            return epc_pkg::CW'(hi);
        end else if (v < lo) begin
            return epc_pkg::CW'(lo);
        end
        return epc_pkg::CW'(v);
    endfunction

    function automatic logic signed [epc_pkg::EW-1:0] clamp_c(
        input logic signed [epc_pkg::EW-1:0] v,
        input logic signed [epc_pkg::EW-1:0] lo,
        input logic signed [epc_pkg::EW-1:0] hi
    );
        if (v > hi) begin
            return hi;
        end else if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

    function automatic logic signed [epc_pkg::EW-1:0] ext_c(
        input logic signed [epc_pkg::CW-1:0] v
    );
        return $signed({{(epc_pkg::EW-epc_pkg::CW){v[epc_pkg::CW-1]}}, v});
    endfunction

    // bit length of an unsigned product
    function automatic logic [epc_pkg::LW-1:0] bitlen(input logic [epc_pkg::PW-1:0] v);
        logic [epc_pkg::LW-1:0] n;
        n = '0;
        for (int i = 0; i < epc_pkg::PW; i++) begin
            if (v[i]) begin
                n = epc_pkg::LW'(i + 1);
            end
        end
        return n;
    endfunction

    // global advance: the output register is free or is being emptied
    logic ce;
    logic m_valid_reg;
    epc_pkg::epc_out_t m_data_reg;

    assign ce      = !m_valid_reg || m_ready;
    assign s_ready = ce;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ---------------------------------------------------------------
    // stage 1: offsets, their magnitudes and the item's case
    // ---------------------------------------------------------------
    logic                   v1_reg;
    epc_pkg::epc_ctx_t      ctx1_reg;
    epc_pkg::epc_ctx_t      ctx1_next;
    logic [epc_pkg::DW-1:0] adx1_reg;
    logic [epc_pkg::DW-1:0] ady1_reg;
    logic [epc_pkg::DW-1:0] dx1;
    logic [epc_pkg::DW-1:0] dy1;
    logic [epc_pkg::DW-1:0] adx1_next;
    logic [epc_pkg::DW-1:0] ady1_next;

    always_comb begin
        dx1 = {s_data.target_x[epc_pkg::CW-1], s_data.target_x}
            - {s_data.center_x[epc_pkg::CW-1], s_data.center_x};
        dy1 = {s_data.target_y[epc_pkg::CW-1], s_data.target_y}
            - {s_data.center_y[epc_pkg::CW-1], s_data.center_y};
        // magnitude of the most negative offset still fits as unsigned
        adx1_next = dx1[epc_pkg::DW-1] ? (~dx1 + epc_pkg::DW'(1)) : dx1;
        ady1_next = dy1[epc_pkg::DW-1] ? (~dy1 + epc_pkg::DW'(1)) : dy1;

        ctx1_next        = '0;
        ctx1_next.mode   = s_data.mode;
        ctx1_next.cx     = s_data.center_x;
        ctx1_next.cy     = s_data.center_y;
        ctx1_next.tx     = s_data.target_x;
        ctx1_next.ty     = s_data.target_y;
        ctx1_next.rx     = s_data.radius_x;
        ctx1_next.ry     = s_data.radius_y;
        ctx1_next.neg_x  = dx1[epc_pkg::DW-1];
        ctx1_next.neg_y  = dy1[epc_pkg::DW-1];
        ctx1_next.zero   = (dx1 == '0) && (dy1 == '0);
        ctx1_next.in_ell = 1'b0;
        // zero horizontal radius wins, which also covers both radii zero
        if (s_data.radius_x == '0) begin
            ctx1_next.kind = epc_pkg::KIND_RX0;
        end else if (s_data.radius_y == '0) begin
            ctx1_next.kind = epc_pkg::KIND_RY0;
        end else begin
            ctx1_next.kind = epc_pkg::KIND_GEN;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            ctx1_reg <= ctx1_next;
            adx1_reg <= adx1_next;
            ady1_reg <= ady1_next;
        end
    end

    // ---------------------------------------------------------------
    // stage 2: exact products A = |dx|*ry, B = |dy|*rx, P = rx*ry
    // ---------------------------------------------------------------
    logic                   v2_reg;
    epc_pkg::epc_ctx_t      ctx2_reg;
    logic [epc_pkg::PW-1:0] a2_reg;
    logic [epc_pkg::PW-1:0] b2_reg;
    logic [epc_pkg::PW-1:0] p2_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            ctx2_reg <= ctx1_reg;
            a2_reg   <= epc_pkg::PW'(adx1_reg) * epc_pkg::PW'(ctx1_reg.ry);
            b2_reg   <= epc_pkg::PW'(ady1_reg) * epc_pkg::PW'(ctx1_reg.rx);
            p2_reg   <= epc_pkg::PW'(ctx1_reg.rx) * epc_pkg::PW'(ctx1_reg.ry);
        end
    end

    // ---------------------------------------------------------------
    // stage 3: 32x32 partial products of the three squares, larger of A and B
    // ---------------------------------------------------------------
    logic                   v3_reg;
    epc_pkg::epc_ctx_t      ctx3_reg;
    epc_pkg::epc_parts_t    pa3_reg;
    epc_pkg::epc_parts_t    pb3_reg;
    epc_pkg::epc_parts_t    pp3_reg;
    logic [epc_pkg::PW-1:0] a3_reg;
    logic [epc_pkg::PW-1:0] b3_reg;
    logic [epc_pkg::PW-1:0] mx3_reg;

    function automatic epc_pkg::epc_parts_t split_sq(input logic [epc_pkg::PW-1:0] v);
        epc_pkg::epc_parts_t r;
        logic [epc_pkg::HW-1:0] h;
        logic [epc_pkg::HW-1:0] l;
        h    = v[epc_pkg::PW-1:epc_pkg::HW];
        l    = v[epc_pkg::HW-1:0];
        r.hh = epc_pkg::PW'(h) * epc_pkg::PW'(h);
        r.hl = epc_pkg::PW'(h) * epc_pkg::PW'(l);
        r.ll = epc_pkg::PW'(l) * epc_pkg::PW'(l);
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (ce) begin
            ctx3_reg <= ctx2_reg;
            pa3_reg  <= split_sq(a2_reg);
            pb3_reg  <= split_sq(b2_reg);
            pp3_reg  <= split_sq(p2_reg);
            a3_reg   <= a2_reg;
            b3_reg   <= b2_reg;
            mx3_reg  <= (a2_reg >= b2_reg) ? a2_reg : b2_reg;
        end
    end

    // ---------------------------------------------------------------
    // stage 4: assemble A^2, B^2, P^2 and find the normalizing length
    // ---------------------------------------------------------------
    logic                   v4_reg;
    epc_pkg::epc_ctx_t      ctx4_reg;
    logic [epc_pkg::QW-1:0] a2q4_reg;
    logic [epc_pkg::QW-1:0] b2q4_reg;
    logic [epc_pkg::QW-1:0] p2q4_reg;
    logic [epc_pkg::PW-1:0] a4_reg;
    logic [epc_pkg::PW-1:0] b4_reg;
    logic [epc_pkg::LW-1:0] len4_reg;

    function automatic logic [epc_pkg::QW-1:0] join_sq(input epc_pkg::epc_parts_t p);
        return (epc_pkg::QW'(p.hh) << epc_pkg::PW)
             + (epc_pkg::QW'(p.hl) << (epc_pkg::HW + 1))
             + epc_pkg::QW'(p.ll);
    endfunction

    always_ff @(posedge aclk) begin
        if (ce) begin
            ctx4_reg <= ctx3_reg;
            a2q4_reg <= join_sq(pa3_reg);
            b2q4_reg <= join_sq(pb3_reg);
            p2q4_reg <= join_sq(pp3_reg);
            a4_reg   <= a3_reg;
            b4_reg   <= b3_reg;
            len4_reg <= bitlen(mx3_reg);
        end
    end

    // ---------------------------------------------------------------
    // stage 5: exact magnet test and normalization of A and B
    // ---------------------------------------------------------------
    logic                     v5_reg;
    epc_pkg::epc_ctx_t        ctx5_reg;
    epc_pkg::epc_ctx_t        ctx5_next;
    logic [epc_pkg::NW-1:0]   na5_reg;
    logic [epc_pkg::NW-1:0]   nb5_reg;
    logic [epc_pkg::NW-1:0]   na5_next;
    logic [epc_pkg::NW-1:0]   nb5_next;
    logic [epc_pkg::QW:0]     sum5;
    logic [epc_pkg::LW-1:0]   sh5;

    always_comb begin
        sum5             = {1'b0, a2q4_reg} + {1'b0, b2q4_reg};
        ctx5_next        = ctx4_reg;
        ctx5_next.in_ell = (sum5 <= {1'b0, p2q4_reg});
        // the larger of A and B lands in [2^30, 2^31); right shifts truncate
        if (len4_reg > epc_pkg::LW'(epc_pkg::NW)) begin
            sh5      = len4_reg - epc_pkg::LW'(epc_pkg::NW);
            na5_next = epc_pkg::NW'(a4_reg >> sh5);
            nb5_next = epc_pkg::NW'(b4_reg >> sh5);
        end else begin
            sh5      = epc_pkg::LW'(epc_pkg::NW) - len4_reg;
            na5_next = epc_pkg::NW'(a4_reg << sh5);
            nb5_next = epc_pkg::NW'(b4_reg << sh5);
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            ctx5_reg <= ctx5_next;
            na5_reg  <= na5_next;
            nb5_reg  <= nb5_next;
        end
    end

    // ---------------------------------------------------------------
    // stage 6: radicand a^2 + b^2
    // ---------------------------------------------------------------
    logic                   v6_reg;
    epc_pkg::epc_ctx_t      ctx6_reg;
    logic [epc_pkg::SW-1:0] q6_reg;
    logic [epc_pkg::NW-1:0] na6_reg;
    logic [epc_pkg::NW-1:0] nb6_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            ctx6_reg <= ctx5_reg;
            q6_reg   <= epc_pkg::SW'(na5_reg) * epc_pkg::SW'(na5_reg)
                      + epc_pkg::SW'(nb5_reg) * epc_pkg::SW'(nb5_reg);
            na6_reg  <= na5_reg;
            nb6_reg  <= nb5_reg;
        end
    end

    // ---------------------------------------------------------------
    // square root: one root bit per stage, two radicand bits consumed each
    // ---------------------------------------------------------------
    logic                    sq_v_reg    [1:epc_pkg::SQ_STEPS];
    epc_pkg::epc_ctx_t       sq_ctx_reg  [1:epc_pkg::SQ_STEPS];
    logic [epc_pkg::SW-1:0]  sq_q_reg    [1:epc_pkg::SQ_STEPS];
    logic [epc_pkg::RMW-1:0] sq_rem_reg  [1:epc_pkg::SQ_STEPS];
    logic [epc_pkg::RTW-1:0] sq_root_reg [1:epc_pkg::SQ_STEPS];
    logic [epc_pkg::NW-1:0]  sq_a_reg    [1:epc_pkg::SQ_STEPS];
    logic [epc_pkg::NW-1:0]  sq_b_reg    [1:epc_pkg::SQ_STEPS];

    for (genvar i = 0; i < epc_pkg::SQ_STEPS; i++) begin : g_sqrt
        logic                    v_in;
        epc_pkg::epc_ctx_t       ctx_in;
        logic [epc_pkg::SW-1:0]  q_in;
        logic [epc_pkg::RMW-1:0] rem_in;
        logic [epc_pkg::RTW-1:0] root_in;
        logic [epc_pkg::NW-1:0]  a_in;
        logic [epc_pkg::NW-1:0]  b_in;
        logic [epc_pkg::RMW+1:0] r_sh;
        logic [epc_pkg::RMW+1:0] trial;
        logic                    ge;

        if (i == 0) begin : g_first
            assign v_in    = v6_reg;
            assign ctx_in  = ctx6_reg;
            assign q_in    = q6_reg;
            assign rem_in  = '0;
            assign root_in = '0;
            assign a_in    = na6_reg;
            assign b_in    = nb6_reg;
        end else begin : g_next
            assign v_in    = sq_v_reg[i];
            assign ctx_in  = sq_ctx_reg[i];
            assign q_in    = sq_q_reg[i];
            assign rem_in  = sq_rem_reg[i];
            assign root_in = sq_root_reg[i];
            assign a_in    = sq_a_reg[i];
            assign b_in    = sq_b_reg[i];
        end

        assign r_sh  = {rem_in, q_in[epc_pkg::SW-1 -: 2]};
        assign trial = {2'b00, root_in, 2'b01};
        assign ge    = (r_sh >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_v_reg[i+1] <= 1'b0;
            end else if (ce) begin
                sq_v_reg[i+1] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                sq_ctx_reg[i+1]  <= ctx_in;
                sq_q_reg[i+1]    <= q_in << 2;
                sq_rem_reg[i+1]  <= ge ? epc_pkg::RMW'(r_sh - trial) : epc_pkg::RMW'(r_sh);
                sq_root_reg[i+1] <= {root_in[epc_pkg::RTW-2:0], ge};
                sq_a_reg[i+1]    <= a_in;
                sq_b_reg[i+1]    <= b_in;
            end
        end
    end

    // ---------------------------------------------------------------
    // two restoring dividers in step: ux = a*2^31/s and uy = b*2^31/s
    // ---------------------------------------------------------------
    logic                   dv_v_reg   [1:epc_pkg::DIV_STEPS];
    epc_pkg::epc_ctx_t      dv_ctx_reg [1:epc_pkg::DIV_STEPS];
    logic [epc_pkg::RTW-1:0] dv_s_reg  [1:epc_pkg::DIV_STEPS];
    logic [epc_pkg::RTW-1:0] dv_rx_reg [1:epc_pkg::DIV_STEPS];
    logic [epc_pkg::RTW-1:0] dv_ry_reg [1:epc_pkg::DIV_STEPS];
    logic [epc_pkg::UW-1:0] dv_qx_reg  [1:epc_pkg::DIV_STEPS];
    logic [epc_pkg::UW-1:0] dv_qy_reg  [1:epc_pkg::DIV_STEPS];

    for (genvar k = 0; k < epc_pkg::DIV_STEPS; k++) begin : g_div
        logic                    v_in;
        epc_pkg::epc_ctx_t       ctx_in;
        logic [epc_pkg::RTW-1:0] s_in;
        logic [epc_pkg::RTW-1:0] rx_in;
        logic [epc_pkg::RTW-1:0] ry_in;
        logic [epc_pkg::UW-1:0]  qx_in;
        logic [epc_pkg::UW-1:0]  qy_in;
        logic                    bx;
        logic                    by;
        logic [epc_pkg::RTW:0]   r2x;
        logic [epc_pkg::RTW:0]   r2y;
        logic                    gex;
        logic                    gey;

        if (k == 0) begin : g_first
            // dividend is the numerator shifted up by 31; its top bits start the remainder
            assign v_in   = sq_v_reg[epc_pkg::SQ_STEPS];
            assign ctx_in = sq_ctx_reg[epc_pkg::SQ_STEPS];
            assign s_in   = sq_root_reg[epc_pkg::SQ_STEPS];
            assign rx_in  = epc_pkg::RTW'(sq_a_reg[epc_pkg::SQ_STEPS] >> 1);
            assign ry_in  = epc_pkg::RTW'(sq_b_reg[epc_pkg::SQ_STEPS] >> 1);
            assign bx     = sq_a_reg[epc_pkg::SQ_STEPS][0];
            assign by     = sq_b_reg[epc_pkg::SQ_STEPS][0];
            assign qx_in  = '0;
            assign qy_in  = '0;
        end else begin : g_next
            assign v_in   = dv_v_reg[k];
            assign ctx_in = dv_ctx_reg[k];
            assign s_in   = dv_s_reg[k];
            assign rx_in  = dv_rx_reg[k];
            assign ry_in  = dv_ry_reg[k];
            assign bx     = 1'b0;
            assign by     = 1'b0;
            assign qx_in  = dv_qx_reg[k];
            assign qy_in  = dv_qy_reg[k];
        end

        assign r2x = {rx_in, bx};
        assign r2y = {ry_in, by};
        assign gex = (r2x >= {1'b0, s_in});
        assign gey = (r2y >= {1'b0, s_in});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_v_reg[k+1] <= 1'b0;
            end else if (ce) begin
                dv_v_reg[k+1] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                dv_ctx_reg[k+1] <= ctx_in;
                dv_s_reg[k+1]   <= s_in;
                dv_rx_reg[k+1]  <= gex ? epc_pkg::RTW'(r2x - {1'b0, s_in})
                                       : epc_pkg::RTW'(r2x);
                dv_ry_reg[k+1]  <= gey ? epc_pkg::RTW'(r2y - {1'b0, s_in})
                                       : epc_pkg::RTW'(r2y);
                dv_qx_reg[k+1]  <= {qx_in[epc_pkg::UW-2:0], gex};
                dv_qy_reg[k+1]  <= {qy_in[epc_pkg::UW-2:0], gey};
            end
        end
    end

    // ---------------------------------------------------------------
    // scale the unit vector back by the radii
    // ---------------------------------------------------------------
    logic                   vm_reg;
    epc_pkg::epc_ctx_t      ctxm_reg;
    logic [epc_pkg::UW-1:0] offx_reg;
    logic [epc_pkg::UW-1:0] offy_reg;
    logic [epc_pkg::PW-1:0] prodx;
    logic [epc_pkg::PW-1:0] prody;

    assign prodx = epc_pkg::PW'(dv_ctx_reg[epc_pkg::DIV_STEPS].rx)
                 * epc_pkg::PW'(dv_qx_reg[epc_pkg::DIV_STEPS]);
    assign prody = epc_pkg::PW'(dv_ctx_reg[epc_pkg::DIV_STEPS].ry)
                 * epc_pkg::PW'(dv_qy_reg[epc_pkg::DIV_STEPS]);

    always_ff @(posedge aclk) begin
        if (ce) begin
            ctxm_reg <= dv_ctx_reg[epc_pkg::DIV_STEPS];
            offx_reg <= prodx[epc_pkg::UNIT_SHIFT +: epc_pkg::UW];
            offy_reg <= prody[epc_pkg::UNIT_SHIFT +: epc_pkg::UW];
        end
    end

    // ---------------------------------------------------------------
    // final selection, saturation and the output register
    // ---------------------------------------------------------------
    logic signed [epc_pkg::EW-1:0] cx_e;
    logic signed [epc_pkg::EW-1:0] cy_e;
    logic signed [epc_pkg::EW-1:0] tx_e;
    logic signed [epc_pkg::EW-1:0] ty_e;
    logic signed [epc_pkg::EW-1:0] rx_e;
    logic signed [epc_pkg::EW-1:0] ry_e;
    logic signed [epc_pkg::EW-1:0] offx_e;
    logic signed [epc_pkg::EW-1:0] offy_e;
    logic signed [epc_pkg::EW-1:0] ox_w;
    logic signed [epc_pkg::EW-1:0] oy_w;
    logic                          degen_w;
    epc_pkg::epc_out_t             m_data_next;

    always_comb begin
        cx_e   = ext_c(ctxm_reg.cx);
        cy_e   = ext_c(ctxm_reg.cy);
        tx_e   = ext_c(ctxm_reg.tx);
        ty_e   = ext_c(ctxm_reg.ty);
        rx_e   = $signed({{(epc_pkg::EW-epc_pkg::RW){1'b0}}, ctxm_reg.rx});
        ry_e   = $signed({{(epc_pkg::EW-epc_pkg::RW){1'b0}}, ctxm_reg.ry});
        offx_e = $signed({{(epc_pkg::EW-epc_pkg::UW){1'b0}}, offx_reg});
        offy_e = $signed({{(epc_pkg::EW-epc_pkg::UW){1'b0}}, offy_reg});
        degen_w = 1'b0;

        unique case (ctxm_reg.kind)
            epc_pkg::KIND_RX0: begin
                // flat ellipse: slide along the vertical segment
                ox_w = cx_e;
                oy_w = clamp_c(ty_e, cy_e - ry_e, cy_e + ry_e);
            end
            epc_pkg::KIND_RY0: begin
                ox_w = clamp_c(tx_e, cx_e - rx_e, cx_e + rx_e);
                oy_w = cy_e;
            end
            default: begin
                if (ctxm_reg.mode && ctxm_reg.in_ell) begin
                    // magnet mode keeps points on or inside the ellipse
                    ox_w = tx_e;
                    oy_w = ty_e;
                end else if (ctxm_reg.zero) begin
                    // no direction to project along: return the centre
                    ox_w    = cx_e;
                    oy_w    = cy_e;
                    degen_w = 1'b1;
                end else begin
                    ox_w = ctxm_reg.neg_x ? (cx_e - offx_e) : (cx_e + offx_e);
                    oy_w = ctxm_reg.neg_y ? (cy_e - offy_e) : (cy_e + offy_e);
                end
            end
        endcase

        m_data_next.out_x      = sat_c(ox_w);
        m_data_next.out_y      = sat_c(oy_w);
        m_data_next.moved      = (m_data_next.out_x != ctxm_reg.tx)
                              || (m_data_next.out_y != ctxm_reg.ty);
        m_data_next.degenerate = degen_w;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            m_data_reg <= m_data_next;
        end
    end

    // valid bits of the fixed stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            v6_reg      <= 1'b0;
            vm_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (ce) begin
            v1_reg      <= s_valid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            v5_reg      <= v4_reg;
            v6_reg      <= v5_reg;
            vm_reg      <= dv_v_reg[epc_pkg::DIV_STEPS];
            m_valid_reg <= vm_reg;
        end
    end

endmodule

// ===== rtl/core/epc_checker.sv =====
module epc_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input epc_pkg::epc_in_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input epc_pkg::epc_out_t m_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // an empty output never blocks the input
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // centre returned for a degenerate item never counts as moved
    a_degen_still: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.degenerate |-> !m_data.moved)
        else $error("degenerate result flagged as moved");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind ellipse_point_clamp epc_checker u_epc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== sim/ellipse_point_clamp_tb.sv =====
module ellipse_point_clamp_tb;
    import epc_pkg::*;

    // pipeline depth of the block, plus margin
    localparam int PIPE_LAT  = 72;
    localparam int DRAIN_CYC = PIPE_LAT + 20;
    localparam int STALL_LIM = 4000;
    localparam int N_RAND    = 450;
    localparam int HOLD_CYC  = 200;

    localparam logic MODE_PLAIN  = 1'b0;
    localparam logic MODE_MAGNET = 1'b1;

    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [RW-1:0]        RMAX = {RW{1'b1}};

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    epc_in_t   s_data;
    logic      m_valid;
    logic      m_ready;
    epc_out_t  m_data;

    ellipse_point_clamp dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // expected projections, oldest first
    epc_out_t proj_q[$];
    int       n_err;
    int       n_in;
    int       n_out;
    int       n_moved;
    int       n_degen;
    bit       calm;      // no idling in the closing stretch
    bit       hold_rx;   // long receiver hold-off requested
    bit       hold_done;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // saturate a wide signed value to the coordinate range
    function automatic logic signed [CW-1:0] sat_coord(input logic signed [CW+2:0] v);
        if (v > CMAX)
            return CMAX;
        if (v < CMIN)
            return CMIN;
        return v[CW-1:0];
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] q);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > q)
            b = b >> 2;
        while (b != 0) begin
            if (q >= r + b) begin
                q = q - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // radial projection of one item onto its ellipse
    function automatic epc_out_t project_point(input epc_in_t p);
        epc_out_t                 o;
        logic signed [CW+2:0]     cx, cy, tx, ty, rx, ry, dx, dy, ox, oy, lo, hi;
        logic [63:0]              adx, ady, a, b, s, ux, uy, offx, offy;
        logic [127:0]             pa, pb, pp, mx, sh;
        logic [255:0]             sum, pp2;
        int                       len;
        cx = p.center_x;
        cy = p.center_y;
        tx = p.target_x;
        ty = p.target_y;
        rx = {1'b0, p.radius_x};
        ry = {1'b0, p.radius_y};
        o.degenerate = 1'b0;
        if (rx == 0) begin
            lo = cy - ry;
            hi = cy + ry;
            ox = cx;
            oy = (ty > hi) ? hi : ((ty < lo) ? lo : ty);
        end else if (ry == 0) begin
            lo = cx - rx;
            hi = cx + rx;
            oy = cy;
            ox = (tx > hi) ? hi : ((tx < lo) ? lo : tx);
        end else begin
            dx = tx - cx;
            dy = ty - cy;
            adx = (dx < 0) ? -dx : dx;
            ady = (dy < 0) ? -dy : dy;
            pa = adx * p.radius_y;
            pb = ady * p.radius_x;
            pp = 128'(p.radius_x) * p.radius_y;
            sum = 256'(pa) * pa + 256'(pb) * pb;
            pp2 = 256'(pp) * pp;
            if (p.mode == MODE_MAGNET && sum <= pp2) begin
                ox = tx;
                oy = ty;
            end else if (adx == 0 && ady == 0) begin
                ox = cx;
                oy = cy;
                o.degenerate = 1'b1;
            end else begin
                mx = (pa >= pb) ? pa : pb;
                len = 0;
                for (int i = 0; i < 128; i++)
                    if (mx[i])
                        len = i + 1;
                if (len > 31) begin
                    sh = pa >> (len - 31);
                    a = sh[63:0];
                    sh = pb >> (len - 31);
                    b = sh[63:0];
                end else begin
                    a = pa[63:0] << (31 - len);
                    b = pb[63:0] << (31 - len);
                end
                s = root64(a * a + b * b);
                if (s == 0)
                    s = 1;
                ux = (a << 31) / s;
                uy = (b << 31) / s;
                sh = (128'(p.radius_x) * ux) >> 31;
                offx = sh[63:0];
                sh = (128'(p.radius_y) * uy) >> 31;
                offy = sh[63:0];
                ox = (dx < 0) ? cx - $signed({1'b0, offx[CW+1:0]})
                              : cx + $signed({1'b0, offx[CW+1:0]});
                oy = (dy < 0) ? cy - $signed({1'b0, offy[CW+1:0]})
                              : cy + $signed({1'b0, offy[CW+1:0]});
            end
        end
        o.out_x = sat_coord(ox);
        o.out_y = sat_coord(oy);
        o.moved = (o.out_x != p.target_x) || (o.out_y != p.target_y);
        return o;
    endfunction

    function automatic logic signed [CW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return CMAX - $urandom_range(0, 3);
            1: return CMIN + $urandom_range(0, 3);
            2: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [RW-1:0] rand_radius();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return RW'(RMAX - $urandom_range(0, 3));
            2: return RW'($urandom_range(1, 32'h0008_0000));
            default: return RW'($urandom);
        endcase
    endfunction

    // mostly points near the ellipse, so the magnet test splits both ways
    function automatic epc_in_t rand_item();
        epc_in_t p;
        p.mode     = 1'($urandom_range(0, 1));
        p.center_x = rand_coord();
        p.center_y = rand_coord();
        p.radius_x = rand_radius();
        p.radius_y = rand_radius();
        if ($urandom_range(0, 3) != 0) begin
            p.target_x = p.center_x + $signed($urandom_range(0, 2 * (p.radius_x >> 4) + 1))
                         * (($urandom_range(0, 1) != 0) ? 1 : -1) * 16;
            p.target_y = p.center_y + $signed($urandom_range(0, 2 * (p.radius_y >> 4) + 1))
                         * (($urandom_range(0, 1) != 0) ? 1 : -1) * 16;
        end else if ($urandom_range(0, 7) == 0) begin
            p.target_x = p.center_x;
            p.target_y = p.center_y;
        end else begin
            p.target_x = rand_coord();
            p.target_y = rand_coord();
        end
        return p;
    endfunction

    // one row of the directed table; has_exp marks a hand-typed answer
    typedef struct {
        epc_in_t  item;
        bit       has_exp;
        epc_out_t answer;
    } vec_row_t;

    vec_row_t vecs[$];

    function automatic vec_row_t mk(input logic m, input logic signed [CW-1:0] cx,
                                    input logic signed [CW-1:0] cy, input logic [RW-1:0] rx,
                                    input logic [RW-1:0] ry, input logic signed [CW-1:0] tx,
                                    input logic signed [CW-1:0] ty, input bit he,
                                    input logic signed [CW-1:0] ex,
                                    input logic signed [CW-1:0] ey,
                                    input logic emv, input logic edg);
        vec_row_t r;
        r.item = '{mode: m, center_x: cx, center_y: cy, radius_x: rx, radius_y: ry,
                   target_x: tx, target_y: ty};
        r.has_exp = he;
        r.answer = '{out_x: ex, out_y: ey, moved: emv, degenerate: edg};
        return r;
    endfunction

    task automatic build_table();
        // target on centre, plain mode: centre back, flagged
        vecs.push_back(mk(MODE_PLAIN, 100, 200, 10, 10, 100, 200, 1, 100, 200, 0, 1));
        // target on centre, magnet mode: inside, unchanged
        vecs.push_back(mk(MODE_MAGNET, 100, 200, 10, 10, 100, 200, 1, 100, 200, 0, 0));
        // zero horizontal radius clamps onto the vertical segment
        vecs.push_back(mk(MODE_PLAIN, 5, 0, 0, 50, 999, 300, 1, 5, 50, 1, 0));
        vecs.push_back(mk(MODE_MAGNET, 5, 0, 0, 50, 5, -20, 1, 5, -20, 0, 0));
        // both radii zero: collapse to the centre
        vecs.push_back(mk(MODE_PLAIN, 7, 9, 0, 0, -40, 40, 1, 7, 9, 1, 0));
        // zero vertical radius clamps onto the horizontal segment
        vecs.push_back(mk(MODE_PLAIN, 0, 3, 50, 0, -300, 77, 1, -50, 3, 1, 0));
        vecs.push_back(mk(MODE_MAGNET, 0, 3, 50, 0, 20, 3, 1, 20, 3, 0, 0));
        // on-axis targets project exactly onto the radius; a magnet point inside stays put
        vecs.push_back(mk(MODE_PLAIN, 0, 0, 1000, 500, 4000, 0, 1, 1000, 0, 1, 0));
        vecs.push_back(mk(MODE_PLAIN, 0, 0, 1000, 500, 0, -3, 1, 0, -500, 1, 0));
        vecs.push_back(mk(MODE_MAGNET, 0, 0, 1000, 500, 10, 10, 1, 10, 10, 0, 0));
        // saturation at both ends
        vecs.push_back(mk(MODE_PLAIN, CMAX, 0, RMAX, 0, CMAX, 0, 1, CMAX, 0, 0, 0));
        vecs.push_back(mk(MODE_PLAIN, 0, CMIN, 0, RMAX, 0, CMIN, 1, 0, CMIN, 0, 0));
        vecs.push_back(mk(MODE_PLAIN, CMAX, CMIN, RMAX, RMAX, CMIN, CMAX, 0, 0, 0, 0, 0));
        vecs.push_back(mk(MODE_MAGNET, CMIN, CMAX, RMAX, RMAX, CMAX, CMIN, 0, 0, 0, 0, 0));
        vecs.push_back(mk(MODE_PLAIN, CMAX, CMAX, RMAX, 1, CMIN, CMIN, 0, 0, 0, 0, 0));
        vecs.push_back(mk(MODE_PLAIN, CMIN, CMIN, 1, RMAX, CMAX, CMAX, 0, 0, 0, 0, 0));
        // oblique points, inside and outside, both modes
        vecs.push_back(mk(MODE_PLAIN, 0, 0, 65536, 32768, 100, 100, 0, 0, 0, 0, 0));
        vecs.push_back(mk(MODE_MAGNET, 0, 0, 65536, 32768, 100, 100, 0, 0, 0, 0, 0));
        vecs.push_back(mk(MODE_MAGNET, -7, 9, 3, 5, 1000, -999, 0, 0, 0, 0, 0));
        vecs.push_back(mk(MODE_PLAIN, 1, 1, RMAX, RMAX, -1, -1, 0, 0, 0, 0, 0));
        vecs.push_back(mk(MODE_PLAIN, 0, 0, 1, 1, 1, 1, 0, 0, 0, 0, 0));
    endtask

    // offer one item and keep it steady until taken
    task automatic send_item(input epc_in_t p, input bit gaps);
        if (gaps && !calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= p;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // sender: directed rows first, then random items
    initial begin
        epc_in_t p;
        n_err = 0;
        calm = 1'b0;
        hold_rx = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        aresetn = 1'b0;
        build_table();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (vecs[i])
            send_item(vecs[i].item, 1'b1);
        for (int i = 0; i < N_RAND; i++) begin
            if (i == 100)
                hold_rx <= 1'b1;  // receiver backs off while we keep pushing
            if (i == N_RAND - 60)
                calm = 1'b1;
            p = rand_item();
            send_item(p, 1'b1);
        end
        s_valid <= 1'b0;
    end

    // input monitor: predict on acceptance, or take the typed answer
    int vec_idx = 0;
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            n_in <= n_in + 1;
            if (vec_idx < vecs.size() && vecs[vec_idx].has_exp)
                proj_q.push_back(vecs[vec_idx].answer);
            else
                proj_q.push_back(project_point(s_data));
            vec_idx++;
        end
    end

    // receiver: random stall bursts plus one long hold-off
    initial begin
        m_ready = 1'b0;
        hold_done = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_rx && !hold_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYC) @(posedge aclk);
                hold_done = 1'b1;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
    end

    // output checker, field by field
    always @(posedge aclk) begin
        epc_out_t e;
        if (aresetn && m_valid && m_ready) begin
            n_out <= n_out + 1;
            if (proj_q.size() == 0) begin
                $display("%0t: result with nothing expected: x=%0d y=%0d", $time,
                         m_data.out_x, m_data.out_y);
                n_err++;
            end else begin
                e = proj_q.pop_front();
                if (m_data.moved)
                    n_moved <= n_moved + 1;
                if (m_data.degenerate)
                    n_degen <= n_degen + 1;
                if (m_data.out_x !== e.out_x) begin
                    $display("%0t: out_x expected %0d got %0d", $time, e.out_x, m_data.out_x);
                    n_err++;
                end
                if (m_data.out_y !== e.out_y) begin
                    $display("%0t: out_y expected %0d got %0d", $time, e.out_y, m_data.out_y);
                    n_err++;
                end
                if (m_data.moved !== e.moved) begin
                    $display("%0t: moved expected %0b got %0b", $time, e.moved, m_data.moved);
                    n_err++;
                end
                if (m_data.degenerate !== e.degenerate) begin
                    $display("%0t: degenerate expected %0b got %0b", $time, e.degenerate,
                             m_data.degenerate);
                    n_err++;
                end
            end
        end
    end

    // watchdog on handshake-free cycles, and the end of run
    initial begin
        int idle;
        int total;
        n_in = 0;
        n_out = 0;
        n_moved = 0;
        n_degen = 0;
        idle = 0;
        @(posedge aclk iff aresetn);
        // the directed table is complete once reset is released
        total = vecs.size() + N_RAND;
        while (n_in < total || proj_q.size() != 0) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle = 0;
            else
                idle++;
            if (idle >= STALL_LIM) begin
                $display("timeout: %0d items in, %0d results out", n_in, n_out);
                $display("== FAIL ==");
                $finish;
            end
        end
        repeat (DRAIN_CYC) @(posedge aclk);
        $display("covered %0d items incl. zero radii, centre hits, saturation, long stall",
                 n_in);
        $display("results %0d, moved %0d, degenerate %0d, mismatches %0d",
                 n_out, n_moved, n_degen, n_err);
        if (n_err == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
